@@ hw/rtl/best_fit_heap_allocator_assert.svh @@
// Assertion macros shared by the heap allocator RTL
`ifndef BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define BFH_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define BFH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/bfh_pkg.sv @@
// Package with widths, codes and table entry type of the heap allocator
`timescale 1ns / 1ps
package bfh_pkg;
    localparam int HEAP_BYTES   = 16384;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_BLOCKS   = 1024;
    localparam int FIELD_W      = 14;
    localparam int ADDR_W       = $clog2(HEAP_BYTES) + 1;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOMEM   = 2'd1;
    localparam logic [1:0] ST_BADPTR  = 2'd2;
    localparam logic       KIND_ALLOC = 1'b0;
    localparam logic       KIND_FREE  = 1'b1;
    typedef struct packed {
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] size;
        logic              free;
    } blk_t;
    localparam int BLK_W = $bits(blk_t);
    typedef struct packed {
        logic                 kind;
        logic [FIELD_W-1:0]   request_bytes;
        logic [FIELD_W-1:0]   payload_offset;
    } req_t;
    typedef struct packed {
        logic [1:0]           status;
        logic [FIELD_W-1:0]   granted_offset;
    } rsp_t;
endpackage

@@ hw/rtl/bfh_if.sv @@
// Valid/ready channel interface carrying one word
`timescale 1ns / 1ps
interface bfh_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/bfh_ram.sv @@
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module bfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ hw/rtl/best_fit_heap_allocator.sv @@
// Top level: best-fit heap allocator with neighbor coalescing
//
// Usage: one input word on in (kind, request_bytes, payload_offset), one
// result word on out (status, granted_offset) per input word.
// Allocate: the block table is scanned one entry per cycle through a single
// RAM port, keeping the smallest fitting free entry. On a hit the table tail
// is shifted up by one (read then write per entry) and the split written.
// Free: scan to the matching offset, then free neighbors are merged and the
// tail shifted down (read then write per moved entry).
// One word is processed at a time; in.ready is low while busy or while a
// result waits. out is a register: it holds while the receiver stalls, and
// the next word is accepted once it is taken.
// Reset: block count returns to one; a clearing pass is not needed, entry
// zero is written in the init state after reset, in is not ready meanwhile.
`timescale 1ns / 1ps
`include "best_fit_heap_allocator_assert.svh"
module best_fit_heap_allocator (
    input  logic clk,
    input  logic rst_n,
    bfh_if.sink   in,
    bfh_if.source out
);
    import bfh_pkg::*;

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_SCAN  = 13'b0000000000100,
        S_DEC   = 13'b0000000001000,
        S_UPRD  = 13'b0000000010000,
        S_UPWR  = 13'b0000000100000,
        S_SPLIT = 13'b0000001000000,
        S_FRD   = 13'b0000010000000,
        S_FMRG  = 13'b0000100000000,
        S_DNRD  = 13'b0001000000000,
        S_DNWR  = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic found_reg, found_next;
    blk_t bestblk_reg, bestblk_next;
    blk_t prev_reg, prev_next;
    blk_t cur_reg, cur_next;
    blk_t hold_reg, hold_next;
    logic rdv_reg, rdv_next;
    logic kind_reg, kind_next;
    logic [ADDR_W-1:0] need_reg, need_next;
    logic [ADDR_W-1:0] pay_reg, pay_next;
    logic [FIELD_W-1:0] req_reg, req_next;
    logic [1:0] nmrg_reg, nmrg_next;
    rsp_t rsp_reg, rsp_next;

    logic we;
    logic [IDX_W-1:0] addr;
    blk_t wdata, rdata;
    logic [BLK_W-1:0] rraw;

    bfh_ram #(.WIDTH(BLK_W), .DEPTH(MAX_BLOCKS)) u_tab (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rraw)
    );
    assign rdata = blk_t'(rraw);

    assign in.ready  = (state_reg == S_IDLE);
    assign out.valid = (state_reg == S_OUT);
    assign out.data  = rsp_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg; ptr_next = ptr_reg; lim_next = lim_reg;
        best_next = best_reg; found_next = found_reg; bestblk_next = bestblk_reg;
        prev_next = prev_reg; cur_next = cur_reg; hold_next = hold_reg;
        rdv_next = 1'b0; kind_next = kind_reg; need_next = need_reg;
        pay_next = pay_reg; req_next = req_reg; nmrg_next = nmrg_reg;
        rsp_next = rsp_reg;
        we = 1'b0; addr = ptr_reg[IDX_W-1:0]; wdata = hold_reg;
        unique case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                addr = '0;
                wdata.off = '0;
                wdata.size = ADDR_W'(HEAP_BYTES - HEADER_BYTES);
                wdata.free = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in.valid)
                begin
                    kind_next = in.data.kind;
                    req_next = in.data.request_bytes;
                    need_next = ADDR_W'(in.data.request_bytes) + ADDR_W'(HEADER_BYTES);
                    pay_next = ADDR_W'(in.data.payload_offset);
                    found_next = 1'b0;
                    ptr_next = '0;
                    state_next = S_SCAN;
                end
            end
            // one read issued per cycle, previous read data checked
            S_SCAN:
            begin
                addr = ptr_reg[IDX_W-1:0];
                if (ptr_reg < cnt_reg && !(kind_reg == KIND_FREE && found_reg))
                begin
                    ptr_next = ptr_reg + 1'b1;
                    rdv_next = 1'b1;
                end
                else if (!rdv_reg)
                begin
                    state_next = S_DEC;
                end
                if (rdv_reg)
                begin
                    if (kind_reg == KIND_ALLOC)
                    begin
                        if (rdata.free && rdata.size >= need_reg &&
                            (!found_reg || rdata.size < bestblk_reg.size))
                        begin
                            found_next = 1'b1;
                            bestblk_next = rdata;
                            best_next = IDX_W'(ptr_reg - 1'b1);
                        end
                    end
                    else if (!found_reg)
                    begin
                        if (rdata.off + ADDR_W'(HEADER_BYTES) == pay_reg)
                        begin
                            found_next = 1'b1;
                            bestblk_next = rdata;
                            best_next = IDX_W'(ptr_reg - 1'b1);
                        end
                    end
                end
            end
            S_DEC:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (!found_reg || cnt_reg >= CNT_W'(MAX_BLOCKS))
                    begin
                        rsp_next = '{ST_NOMEM, '0};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        ptr_next = cnt_reg - 1'b1;
                        state_next = (cnt_reg - 1'b1 > CNT_W'(best_reg)) ? S_UPRD : S_SPLIT;
                    end
                end
                else if (!found_reg)
                begin
                    rsp_next = '{ST_BADPTR, '0};
                    state_next = S_OUT;
                end
                else
                begin
                    // fetch previous neighbor first (the entry itself when it is entry zero)
                    ptr_next = CNT_W'(best_reg);
                    nmrg_next = 2'd0;
                    addr = (best_reg != '0) ? best_reg - 1'b1 : best_reg;
                    state_next = S_FRD;
                end
            end
            // shift tail up: read ptr, write ptr+1
            S_UPRD:
            begin
                addr = ptr_reg[IDX_W-1:0];
                state_next = S_UPWR;
            end
            S_UPWR:
            begin
                we = 1'b1;
                addr = IDX_W'(ptr_reg + 1'b1);
                wdata = rdata;
                ptr_next = ptr_reg - 1'b1;
                state_next = (ptr_reg - 1'b1 > CNT_W'(best_reg)) ? S_UPRD : S_SPLIT;
            end
            S_SPLIT:
            begin
                if (!found_reg)
                begin
                    we = 1'b1;
                    addr = best_reg;
                    wdata.off = bestblk_reg.off;
                    wdata.size = ADDR_W'(req_reg);
                    wdata.free = 1'b0;
                    found_next = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    rsp_next = '{ST_OK, FIELD_W'(bestblk_reg.off + ADDR_W'(HEADER_BYTES))};
                    state_next = S_OUT;
                end
                else
                begin
                    we = 1'b1;
                    addr = best_reg + 1'b1;
                    wdata.off = bestblk_reg.off + need_reg;
                    wdata.size = bestblk_reg.size - need_reg;
                    wdata.free = 1'b1;
                    found_next = 1'b0;
                end
            end
            // free: nmrg 0 prev read pending, 1 next read pending
            S_FRD:
            begin
                if (nmrg_reg == 2'd0)
                begin
                    prev_next = rdata;
                    addr = best_reg + 1'b1;
                    nmrg_next = 2'd1;
                end
                else
                begin
                    cur_next = rdata;
                    state_next = S_FMRG;
                end
            end
            S_FMRG:
            begin
                hold_next = bestblk_reg;
                hold_next.free = 1'b1;
                lim_next = '0;
                if (CNT_W'(best_reg) + 1'b1 < cnt_reg && cur_reg.free)
                begin
                    hold_next.size = bestblk_reg.size + cur_reg.size + ADDR_W'(HEADER_BYTES);
                    lim_next = CNT_W'(1);
                end
                ptr_next = CNT_W'(best_reg);
                if (best_reg != '0 && prev_reg.free)
                begin
                    hold_next.off = prev_reg.off;
                    hold_next.size = prev_reg.size + hold_next.size + ADDR_W'(HEADER_BYTES);
                    ptr_next = CNT_W'(best_reg) - 1'b1;
                    lim_next = lim_next + 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                we = 1'b1;
                addr = ptr_reg[IDX_W-1:0];
                wdata = hold_reg;
                cnt_next = cnt_reg - lim_reg;
                ptr_next = ptr_reg + 1'b1;
                if (lim_reg != '0 && ptr_reg + 1'b1 < cnt_reg - lim_reg)
                begin
                    state_next = S_DNRD;
                end
                else
                begin
                    rsp_next = '{ST_OK, '0};
                    state_next = S_OUT;
                end
            end
            // shift tail down by lim: read ptr+lim, write ptr
            S_DNRD:
            begin
                addr = IDX_W'(ptr_reg + lim_reg);
                state_next = S_DNWR;
            end
            S_DNWR:
            begin
                we = 1'b1;
                addr = ptr_reg[IDX_W-1:0];
                wdata = rdata;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg + 1'b1 < cnt_reg)
                begin
                    state_next = S_DNRD;
                end
                else
                begin
                    rsp_next = '{ST_OK, '0};
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg <= CNT_W'(1);
            rdv_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            rdv_reg <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next; lim_reg <= lim_next; best_reg <= best_next;
        found_reg <= found_next; bestblk_reg <= bestblk_next; prev_reg <= prev_next;
        cur_reg <= cur_next; hold_reg <= hold_next; kind_reg <= kind_next;
        need_reg <= need_next; pay_reg <= pay_next; req_reg <= req_next;
        nmrg_reg <= nmrg_next; rsp_reg <= rsp_next;
    end

    `BFH_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg != '0 && cnt_reg <= CNT_W'(MAX_BLOCKS))
    `BFH_ASSERT_IMP(a_ready_out, in.ready, !out.valid)
    `BFH_ASSERT_NEXT(a_out_hold, out.valid && !out.ready, out.valid && $stable(rsp_reg))
endmodule
